// ----- hdl/fir_dec_pkg.sv -----
// Shared constants and the tap coefficient table of the decimating FIR recorder.
`default_nettype none

package fir_dec_pkg;

   // Field widths
   localparam int SAMPLE_W   = 12;
   localparam int FACTOR_W   = 5;
   localparam int PHASE_W    = 4;
   localparam int INDEX_W    = 13;
   localparam int COEF_W     = 16;
   localparam int TAP_ADDR_W = 6;    // enough for the largest tap count
   localparam int ACC_W      = 32;
   localparam int FRAC_BITS  = 15;

   // Defaults and limits
   localparam int DEF_TAPS         = 45;
   localparam int DEF_RECORD_DEPTH = 8192;
   localparam int COEF_COUNT       = 45;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd4;
   localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 5'd16;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 12'hFFF;

   // Q15 low-pass taps, newest sample first; taps past the table are zero
   function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_ADDR_W-1:0] t);
      logic signed [COEF_W-1:0] c;
      case (t)
         6'd0:  c = 16'sd731;
         6'd1:  c = 16'sd578;
         6'd2:  c = 16'sd527;
         6'd3:  c = 16'sd248;
         6'd4:  c = -16'sd213;
         6'd5:  c = -16'sd717;
         6'd6:  c = -16'sd1074;
         6'd7:  c = -16'sd1126;
         6'd8:  c = -16'sd822;
         6'd9:  c = -16'sd260;
         6'd10: c = 16'sd326;
         6'd11: c = 16'sd662;
         6'd12: c = 16'sd548;
         6'd13: c = -16'sd33;
         6'd14: c = -16'sd870;
         6'd15: c = -16'sd1576;
         6'd16: c = -16'sd1722;
         6'd17: c = -16'sd1009;
         6'd18: c = 16'sd590;
         6'd19: c = 16'sd2784;
         6'd20: c = 16'sd5030;
         6'd21: c = 16'sd6708;
         6'd22: c = 16'sd7329;
         6'd23: c = 16'sd6708;
         6'd24: c = 16'sd5030;
         6'd25: c = 16'sd2784;
         6'd26: c = 16'sd590;
         6'd27: c = -16'sd1009;
         6'd28: c = -16'sd1722;
         6'd29: c = -16'sd1576;
         6'd30: c = -16'sd870;
         6'd31: c = -16'sd33;
         6'd32: c = 16'sd548;
         6'd33: c = 16'sd662;
         6'd34: c = 16'sd326;
         6'd35: c = -16'sd260;
         6'd36: c = -16'sd822;
         6'd37: c = -16'sd1126;
         6'd38: c = -16'sd1074;
         6'd39: c = -16'sd717;
         6'd40: c = -16'sd213;
         6'd41: c = 16'sd248;
         6'd42: c = 16'sd527;
         6'd43: c = 16'sd578;
         6'd44: c = 16'sd731;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/fir_filter_decimate_recorder.sv -----
// Top level: Q15 FIR low-pass over a circular sample memory, with decimated record numbering.
//
//  channel   dir  handshake               payload
//  req_      in   req_tvalid/req_tready   req_tdata  {restart, sample}
//  rsp_      out  rsp_tvalid/rsp_tready   rsp_tdata  {record_full, record_index, kept, filtered}
//  csr_      in   csr_valid/csr_ready     csr_data   decimation_factor
//
// Each request reads the sample memory once per tap, then drains the multiply/accumulate
// pipeline, and finally clips the sum and loads it into the output register.
// A new request is taken as soon as the filter is idle, even while the previous result
// waits in the output register; the result load waits only if that register is still full.
// Reset is synchronous; per-entry valid bits make the sample memory read as zero at once.
`default_nettype none

module fir_filter_decimate_recorder #(
   parameter int TAPS         = fir_dec_pkg::DEF_TAPS,
   parameter int RECORD_DEPTH = fir_dec_pkg::DEF_RECORD_DEPTH
) (
   input  wire  logic                              clock,
   input  wire  logic                              reset,
   // request: [11:0] sample, [12] restart, [15:13] zero
   input  wire  logic [15:0]                       req_tdata,
   input  wire  logic                              req_tvalid,
   output logic                                    req_tready,
   // response: [11:0] filtered, [12] kept, [25:13] record_index, [26] record_full, [31:27] zero
   output logic [31:0]                             rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire  logic                              rsp_tready,
   // decimation factor write
   input  wire  logic [fir_dec_pkg::FACTOR_W-1:0]  csr_data,
   input  wire  logic                              csr_valid,
   output logic                                    csr_ready
);
   import fir_dec_pkg::*;

   localparam int IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int CNT_W  = $clog2(RECORD_DEPTH + 1);
   localparam int PROD_W = COEF_W + SAMPLE_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(RECORD_DEPTH - 1);
   localparam logic signed [ACC_W-1:0] ACC_TOP = ACC_W'(longint'(4095) << FRAC_BITS);

   typedef enum logic [1:0] {IDLE, RUN, DRAIN, FINISH} state_type;

   state_type                   state_ff;
   logic [FACTOR_W-1:0]         factor_ff;
   logic [IDX_W-1:0]            wpos_ff, wpos_in;
   logic [IDX_W-1:0]            ridx_ff;
   logic [IDX_W-1:0]            tap_ff;
   logic [TAPS-1:0]             valid_ff;
   logic [PHASE_W-1:0]          phase_ff, phase_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        full_ff, full_in;
   logic                        kept_ff, kept_in;
   logic [INDEX_W-1:0]          rindex_ff, rindex_in;

   // MAC pipeline
   logic [SAMPLE_W-1:0]         dline_mem [TAPS];
   logic [SAMPLE_W-1:0]         rdata_ff;
   logic                        rvalid_ff;
   logic signed [COEF_W-1:0]    coef_ff;
   logic                        s1_ff, s2_ff;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]     acc_ff;
   logic [SAMPLE_W-1:0]         filtered_in;

   logic                        rsp_valid_ff;
   logic [31:0]                 rsp_data_ff;
   logic                        rsp_load;

   logic                        req_fire;
   logic [SAMPLE_W-1:0]         req_sample;
   logic                        req_restart;
   logic [FACTOR_W-1:0]         factor_eff;
   logic [FACTOR_W-1:0]         phase_next;
   logic                        hit;
   logic [CNT_W-1:0]            count_base;
   logic                        full_base;
   logic                        out_free;

   assign req_tready  = (state_ff == IDLE) && !reset;
   assign req_fire    = req_tvalid && req_tready;
   assign req_sample  = req_tdata[SAMPLE_W-1:0];
   assign req_restart = req_tdata[SAMPLE_W];
   assign csr_ready   = !reset;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_load    = (state_ff == FINISH) && out_free;

   // Config register
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_RESET;
      end else if (csr_valid) begin
         factor_ff <= csr_data;
      end
   end

   // Decimation and record window bookkeeping, resolved when the request is taken
   always_comb begin
      factor_eff = factor_ff;
      if (factor_ff == '0) factor_eff = FACTOR_W'(1);
      if (factor_ff > FACTOR_MAX) factor_eff = FACTOR_MAX;
      phase_next = FACTOR_W'(phase_ff) + FACTOR_W'(1);
      hit        = (phase_next >= factor_eff);
      count_base = req_restart ? '0 : count_ff;
      full_base  = req_restart ? 1'b0 : full_ff;
      phase_in   = hit ? '0 : phase_next[PHASE_W-1:0];
      count_in   = count_base;
      full_in    = full_base;
      kept_in    = 1'b0;
      rindex_in  = '0;
      if (hit && (count_base <= LAST_CNT)) begin
         kept_in   = 1'b1;
         rindex_in = INDEX_W'(count_base);
         count_in  = count_base + CNT_W'(1);
         if (count_base == LAST_CNT) full_in = 1'b1;
      end
      wpos_in = (wpos_ff == LAST_IDX) ? '0 : wpos_ff + IDX_W'(1);
   end

   // Sample memory: one write on acceptance, one registered read per tap
   always_ff @(posedge clock) begin
      if (req_fire) dline_mem[wpos_ff] <= req_sample;
      rdata_ff <= dline_mem[ridx_ff];
   end

   // Multiply stage and clip
   always_comb begin
      prod_in = PROD_W'(coef_ff * $signed({1'b0, rvalid_ff ? rdata_ff : '0}));
      if (acc_ff < 0)            filtered_in = '0;
      else if (acc_ff > ACC_TOP) filtered_in = SAMPLE_MAX;
      else                       filtered_in = acc_ff[FRAC_BITS +: SAMPLE_W];
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rvalid_ff <= valid_ff[ridx_ff];
      coef_ff   <= tap_coef(TAP_ADDR_W'(tap_ff));
      prod_ff   <= prod_in;
      if (req_fire) begin
         acc_ff <= '0;
      end else if (s2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // Control state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         wpos_ff      <= '0;
         ridx_ff      <= '0;
         tap_ff       <= '0;
         valid_ff     <= '0;
         phase_ff     <= '0;
         count_ff     <= '0;
         full_ff      <= 1'b0;
         kept_ff      <= 1'b0;
         rindex_ff    <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         s1_ff <= (state_ff == RUN);
         s2_ff <= s1_ff;
         // output register: load wins over the drain of the previous response
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_fire) begin
                  valid_ff[wpos_ff] <= 1'b1;
                  ridx_ff   <= wpos_ff;
                  tap_ff    <= '0;
                  wpos_ff   <= wpos_in;
                  phase_ff  <= phase_in;
                  count_ff  <= count_in;
                  full_ff   <= full_in;
                  kept_ff   <= kept_in;
                  rindex_ff <= rindex_in;
                  state_ff  <= RUN;
               end
            end
            RUN: begin
               // walk back from the newest sample, one tap per cycle
               ridx_ff <= (ridx_ff == '0) ? LAST_IDX : ridx_ff - IDX_W'(1);
               tap_ff  <= tap_ff + IDX_W'(1);
               if (tap_ff == LAST_IDX) state_ff <= DRAIN;
            end
            DRAIN: begin
               if (!s1_ff && !s2_ff) state_ff <= FINISH;
            end
            FINISH: begin
               if (rsp_load) begin
                  rsp_data_ff  <= {5'd0, full_ff, rindex_ff, kept_ff, filtered_in};
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire
